// ===== design/pids_pkg.sv =====
// Package for the positional insert/delete stack: sizes, command codes,
// status codes and sequencer states. No dependencies.
package pids_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Port field widths
  localparam int CMD_W  = 3;
  localparam int POS_W  = 6;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH     = 3'd0,
    CMD_INSERT   = 3'd1,
    CMD_POP      = 3'd2,
    CMD_DELETE   = 3'd3,
    CMD_READ_IDX = 3'd4,
    CMD_READ_TOP = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADPOS = 2'd3
  } stat_t;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_DECODE    = 6'b000010,
    S_SHIFT_RD  = 6'b000100,
    S_SHIFT_WR  = 6'b001000,
    S_INS_PUT   = 6'b010000,
    S_READ_WAIT = 6'b100000
  } state_t;

endpackage

// ===== design/positional_insert_delete_stack.sv =====
// Bounded stack of data words with positional insert and delete.
// Depends on pids_pkg for sizes, command/status codes and states.
//
// One transaction is handled at a time by a small sequencer around a single
// storage array with one write port and one registered read port. Push, pop,
// insert at the top, delete of the top entry and failed commands finish in the
// decode state; reads pass through a wait state for the registered read port.
// Insert at position p with n entries held moves n-p entries, delete at p
// moves n-p-1 entries; each move is a read then a write on the array, and an
// insert that moves entries ends with one more write for the new word. The
// result sits in an output register; a new transaction is taken once the
// sequencer is idle and the output register is free or being drained in that
// cycle.
module positional_insert_delete_stack (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pids_pkg::CMD_W-1:0]  in_command,
  input  logic [pids_pkg::POS_W-1:0]  in_position,
  input  logic [pids_pkg::WORD_W-1:0] in_data_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pids_pkg::WORD_W-1:0] out_data_out,
  output logic [pids_pkg::STAT_W-1:0] out_status,
  output logic [pids_pkg::CNT_W-1:0]  out_count
);
  import pids_pkg::*;

  state_t              state_r, state_nxt;
  cmd_t                cmd_r;
  logic [ADDR_W-1:0]   pos_r;
  logic [DATA_W-1:0]   word_r;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]    held_r, held_nxt;

  logic [DATA_W-1:0]   mem [DEPTH];
  logic [DATA_W-1:0]   rd_data_r;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [DATA_W-1:0]   mem_wdata;

  logic                done;
  stat_t               res_status;
  logic [DATA_W-1:0]   res_data;

  logic                out_valid_r;
  logic [WORD_W-1:0]   out_data_r;
  stat_t               out_status_r;
  logic [CNT_W-1:0]    out_count_r;

  logic                in_accept;
  logic                full;
  logic [CNT_W-1:0]    pos_ext;
  logic [CNT_W-1:0]    idx_ext;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign full      = (held_r == CNT_W'(DEPTH));
  assign pos_ext   = CNT_W'(pos_r);
  assign idx_ext   = CNT_W'(idx_r);

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    held_nxt   = held_r;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = rd_data_r;
    mem_raddr  = idx_r;
    done       = 1'b0;
    res_status = STAT_OK;
    res_data   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        case (cmd_r)
          CMD_PUSH: begin
            done      = 1'b1;
            state_nxt = S_IDLE;
            if (full) begin
              res_status = STAT_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = held_r[ADDR_W-1:0];
              mem_wdata = word_r;
              held_nxt  = held_r + 1'b1;
            end
          end
          CMD_INSERT: begin
            if (full) begin
              done       = 1'b1;
              res_status = STAT_FULL;
              state_nxt  = S_IDLE;
            end else if (pos_ext > held_r) begin
              done       = 1'b1;
              res_status = STAT_BADPOS;
              state_nxt  = S_IDLE;
            end else if (pos_ext == held_r) begin
              done      = 1'b1;
              mem_we    = 1'b1;
              mem_waddr = pos_r;
              mem_wdata = word_r;
              held_nxt  = held_r + 1'b1;
              state_nxt = S_IDLE;
            end else begin
              // start at the top and move entries up one by one
              idx_nxt   = held_r[ADDR_W-1:0];
              state_nxt = S_SHIFT_RD;
            end
          end
          CMD_POP: begin
            done      = 1'b1;
            state_nxt = S_IDLE;
            if (held_r == '0) begin
              res_status = STAT_EMPTY;
            end else begin
              held_nxt = held_r - 1'b1;
            end
          end
          CMD_DELETE: begin
            if (pos_ext >= held_r) begin
              done       = 1'b1;
              res_status = STAT_BADPOS;
              state_nxt  = S_IDLE;
            end else if (pos_ext + 1'b1 < held_r) begin
              idx_nxt   = pos_r;
              state_nxt = S_SHIFT_RD;
            end else begin
              // deleting the top entry: nothing to move
              done      = 1'b1;
              held_nxt  = held_r - 1'b1;
              state_nxt = S_IDLE;
            end
          end
          CMD_READ_IDX: begin
            mem_raddr = pos_r;
            if (held_r == '0) begin
              done       = 1'b1;
              res_status = STAT_EMPTY;
              state_nxt  = S_IDLE;
            end else if (pos_ext >= held_r) begin
              done       = 1'b1;
              res_status = STAT_BADPOS;
              state_nxt  = S_IDLE;
            end else begin
              state_nxt = S_READ_WAIT;
            end
          end
          CMD_READ_TOP: begin
            mem_raddr = ADDR_W'(held_r - 1'b1);
            if (held_r == '0) begin
              done       = 1'b1;
              res_status = STAT_EMPTY;
              state_nxt  = S_IDLE;
            end else begin
              state_nxt = S_READ_WAIT;
            end
          end
          default: begin
            done       = 1'b1;
            res_status = STAT_BADPOS;
            state_nxt  = S_IDLE;
          end
        endcase
      end

      S_SHIFT_RD: begin
        mem_raddr = (cmd_r == CMD_INSERT) ? idx_r - 1'b1 : idx_r + 1'b1;
        state_nxt = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        mem_we = 1'b1;
        if (cmd_r == CMD_INSERT) begin
          idx_nxt = idx_r - 1'b1;
          if (idx_nxt == pos_r) begin
            state_nxt = S_INS_PUT;
          end else begin
            state_nxt = S_SHIFT_RD;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
          if (idx_ext + 2'd2 < held_r) begin
            state_nxt = S_SHIFT_RD;
          end else begin
            done      = 1'b1;
            held_nxt  = held_r - 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end

      S_INS_PUT: begin
        done      = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = word_r;
        held_nxt  = held_r + 1'b1;
        state_nxt = S_IDLE;
      end

      S_READ_WAIT: begin
        done      = 1'b1;
        res_data  = rd_data_r;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Storage array: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      held_r  <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Hold the transaction's fields for the whole sequence
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r  <= cmd_t'(in_command);
      pos_r  <= in_position[ADDR_W-1:0];
      word_r <= in_data_in[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r   <= WORD_W'(res_data);
      out_status_r <= res_status;
      out_count_r  <= held_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;

  // Checks
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(DEPTH))
    else $error("held count above depth");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input not stalled while sequencer busy");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r == held_r))
    else $error("pending result count differs from held count");

  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != S_IDLE))
    else $error("array written while idle");

endmodule
